[design/gcs_pkg.sv]
// Shared constants, types and codes of the grid coordinate shuffler.
`default_nettype none

package gcs_pkg;

    localparam int MAX_SIDE    = 16;
    localparam int TABLE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int COORD_W     = $clog2(MAX_SIDE);
    localparam int SIDEV_W     = $clog2(MAX_SIDE + 1);

    localparam int SIDE_W   = 5;
    localparam int OPCODE_W = 2;
    localparam int RAND_W   = 31;
    localparam int CELL_W   = 4;
    localparam int STEP_W   = $clog2(RAND_W);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_GRID_SIDE = '0;
    localparam logic [SIDE_W-1:0]    GRID_SIDE_RESET = SIDE_W'(16);

    typedef enum logic [OPCODE_W-1:0] {
        OP_START   = 2'd0,
        OP_SHUFFLE = 2'd1,
        OP_READ    = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_DIV,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_RD_PTR,
        ST_RD_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } cell_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        cell_t            wdata;
    } ram_req_t;

endpackage

`default_nettype wire

[design/gcs_req_if.sv]
// Request channel interface: opcode and random word with valid/ready.
`default_nettype none

interface gcs_req_if;
    import gcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [RAND_W-1:0]   random_word;

    modport source (output valid, output opcode, output random_word, input ready);
    modport sink (input valid, input opcode, input random_word, output ready);
endinterface

`default_nettype wire

[design/gcs_rsp_if.sv]
// Response channel interface: cell coordinates and status flags with valid/ready.
`default_nettype none

interface gcs_rsp_if;
    import gcs_pkg::*;

    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_row;
    logic [CELL_W-1:0] cell_col;
    logic              shuffle_done;
    logic              last;

    modport source (output valid, output cell_row, output cell_col, output shuffle_done,
                    output last, input ready);
    modport sink (input valid, input cell_row, input cell_col, input shuffle_done,
                  input last, output ready);
endinterface

`default_nettype wire

[design/gcs_mod_unit.sv]
// Bit-serial restoring remainder unit: random word modulo the shuffle bound.
`default_nettype none

module gcs_mod_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [gcs_pkg::RAND_W-1:0]  dividend,
    input  logic [gcs_pkg::COUNT_W-1:0] divisor,
    output logic                        done,
    output logic [gcs_pkg::COUNT_W-1:0] remainder
);
    import gcs_pkg::*;

    logic                busy_reg;
    logic                busy_next;
    logic                done_reg;
    logic                done_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic [RAND_W-1:0]   dvd_reg;
    logic [RAND_W-1:0]   dvd_next;
    logic [COUNT_W-1:0]  rem_reg;
    logic [COUNT_W-1:0]  rem_next;
    logic [COUNT_W-1:0]  dsr_reg;
    logic [COUNT_W-1:0]  dsr_next;
    logic [COUNT_W:0]    trial;
    logic                fits;

    assign trial = {rem_reg, dvd_reg[RAND_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(RAND_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? COUNT_W'(trial - {1'b0, dsr_reg}) : COUNT_W'(trial);
            dvd_next = {dvd_reg[RAND_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[design/gcs_cell_ram.sv]
// Single-port cell table memory with registered read data.
`default_nettype none

module gcs_cell_ram (
    input  logic              clk,
    input  gcs_pkg::ram_req_t ram,
    output gcs_pkg::cell_t    rdata
);
    import gcs_pkg::*;

    cell_t mem [TABLE_DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ram.we)
        begin
            mem[ram.addr] <= ram.wdata;
        end
        else
        begin
            rdata_reg <= mem[ram.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/grid_coordinate_shuffler.sv]
// Top level of the grid coordinate shuffler: sequencer, registers and APB port.
// A start transaction fills the cell table in row-major order, one cell per cycle; a shuffle
// transaction with entries left to swap waits on the bit-serial remainder unit (31 remainder
// steps) and then swaps two table entries through the single-port table. One transaction is
// worked on at a time; the next is taken while the previous response still waits at the output.
// The grid side register at address 0 is sampled only by a start.
`default_nettype none

module grid_coordinate_shuffler (
    input  logic                           clk,
    input  logic                           rst_n,
    gcs_req_if.sink                        req,
    gcs_rsp_if.source                      rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gcs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gcs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gcs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import gcs_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [SIDE_W-1:0]  grid_side_reg;
    logic [SIDE_W-1:0]  grid_side_next;
    logic [SIDEV_W-1:0] side_reg;
    logic [SIDEV_W-1:0] side_next;
    logic [COUNT_W-1:0] active_reg;
    logic [COUNT_W-1:0] active_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   ptr_next;
    logic [COORD_W-1:0] fill_row_reg;
    logic [COORD_W-1:0] fill_row_next;
    logic [COORD_W-1:0] fill_col_reg;
    logic [COORD_W-1:0] fill_col_next;
    logic [IDX_W-1:0]   fill_k_reg;
    logic [IDX_W-1:0]   fill_k_next;
    cell_t              tmp_reg;
    cell_t              tmp_next;
    logic [CELL_W-1:0]  res_row_reg;
    logic [CELL_W-1:0]  res_row_next;
    logic [CELL_W-1:0]  res_col_reg;
    logic [CELL_W-1:0]  res_col_next;
    logic               res_last_reg;
    logic               res_last_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CELL_W-1:0]  out_row_reg;
    logic [CELL_W-1:0]  out_row_next;
    logic [CELL_W-1:0]  out_col_reg;
    logic [CELL_W-1:0]  out_col_next;
    logic               out_done_reg;
    logic               out_done_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic               accept;
    logic               cfg_write;
    logic               cfg_hit;
    logic [SIDEV_W-1:0] side_eff;
    logic               div_start;
    logic [COUNT_W-1:0] div_divisor;
    logic               div_done;
    logic [COUNT_W-1:0] div_rem;
    ram_req_t           ram;
    cell_t              ram_rdata;
    logic               read_last;

    gcs_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req.random_word),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    gcs_cell_ram u_ram (
        .clk   (clk),
        .ram   (ram),
        .rdata (ram_rdata)
    );

    assign accept      = req.valid && (state_reg == ST_IDLE);
    assign cfg_hit     = (paddr[APB_ADDR_W-1:2] == REG_GRID_SIDE);
    assign cfg_write   = psel && penable && pwrite && cfg_hit;
    assign pready      = 1'b1;
    assign prdata      = cfg_hit ? APB_DATA_W'(grid_side_reg) : '0;
    assign div_divisor = COUNT_W'(idx_reg) + COUNT_W'(1);
    assign read_last   = ((COUNT_W'(ptr_reg) + COUNT_W'(1)) >= active_reg);

    always_comb
    begin
        if (grid_side_reg == '0)
        begin
            side_eff = SIDEV_W'(1);
        end
        else if (int'(grid_side_reg) > MAX_SIDE)
        begin
            side_eff = SIDEV_W'(MAX_SIDE);
        end
        else
        begin
            side_eff = SIDEV_W'(grid_side_reg);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        grid_side_next = cfg_write ? pwdata[SIDE_W-1:0] : grid_side_reg;
        side_next      = side_reg;
        active_next    = active_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        fill_row_next  = fill_row_reg;
        fill_col_next  = fill_col_reg;
        fill_k_next    = fill_k_reg;
        tmp_next       = tmp_reg;
        res_row_next   = res_row_reg;
        res_col_next   = res_col_reg;
        res_last_next  = res_last_reg;
        out_valid_next = rsp.ready ? 1'b0 : out_valid_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;
        div_start      = 1'b0;
        ram.we         = 1'b0;
        ram.addr       = ptr_reg;
        ram.wdata      = tmp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_row_next  = '0;
                    res_col_next  = '0;
                    res_last_next = 1'b0;
                    state_next    = ST_EMIT;
                    priority if (req.opcode == OP_START)
                    begin
                        side_next     = side_eff;
                        active_next   = COUNT_W'(side_eff) * COUNT_W'(side_eff);
                        idx_next      = IDX_W'(active_next - COUNT_W'(1));
                        ptr_next      = '0;
                        fill_row_next = '0;
                        fill_col_next = '0;
                        fill_k_next   = '0;
                        state_next    = ST_FILL;
                    end
                    else if (req.opcode == OP_SHUFFLE)
                    begin
                        if (active_reg != '0 && idx_reg != '0
                            && COUNT_W'(idx_reg) < active_reg)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    else if (req.opcode == OP_READ)
                    begin
                        if (active_reg != '0 && COUNT_W'(ptr_reg) < active_reg)
                        begin
                            state_next = ST_RD_PTR;
                        end
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FILL:
            begin
                ram.we        = 1'b1;
                ram.addr      = fill_k_reg;
                ram.wdata.row = fill_row_reg;
                ram.wdata.col = fill_col_reg;
                fill_k_next   = fill_k_reg + 1'b1;
                if (fill_col_reg == COORD_W'(side_reg - 1'b1))
                begin
                    fill_col_next = '0;
                    fill_row_next = fill_row_reg + 1'b1;
                end
                else
                begin
                    fill_col_next = fill_col_reg + 1'b1;
                end
                if (COUNT_W'(fill_k_reg) == active_reg - COUNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I:
            begin
                ram.addr   = idx_reg;
                state_next = ST_RD_J;
            end
            ST_RD_J:
            begin
                ram.addr   = IDX_W'(div_rem);
                tmp_next   = ram_rdata;
                state_next = ST_WR_I;
            end
            ST_WR_I:
            begin
                ram.we     = 1'b1;
                ram.addr   = idx_reg;
                ram.wdata  = ram_rdata;
                state_next = ST_WR_J;
            end
            ST_WR_J:
            begin
                ram.we     = 1'b1;
                ram.addr   = IDX_W'(div_rem);
                ram.wdata  = tmp_reg;
                idx_next   = idx_reg - 1'b1;
                state_next = ST_EMIT;
            end
            ST_RD_PTR:
            begin
                ram.addr   = ptr_reg;
                state_next = ST_RD_WAIT;
            end
            ST_RD_WAIT:
            begin
                res_row_next  = CELL_W'(ram_rdata.row);
                res_col_next  = CELL_W'(ram_rdata.col);
                res_last_next = read_last;
                ptr_next      = read_last ? '0 : ptr_reg + 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = res_row_reg;
                    out_col_next   = res_col_reg;
                    out_done_next  = (active_reg != '0) && (idx_reg == '0);
                    out_last_next  = res_last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            grid_side_reg <= GRID_SIDE_RESET;
            active_reg    <= '0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grid_side_reg <= grid_side_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg     <= side_next;
        fill_row_reg <= fill_row_next;
        fill_col_reg <= fill_col_next;
        fill_k_reg   <= fill_k_next;
        tmp_reg      <= tmp_next;
        res_row_reg  <= res_row_next;
        res_col_reg  <= res_col_next;
        res_last_reg <= res_last_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_done_reg <= out_done_next;
        out_last_reg <= out_last_next;
    end

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.cell_row     = out_row_reg;
    assign rsp.cell_col     = out_col_reg;
    assign rsp.shuffle_done = out_done_reg;
    assign rsp.last         = out_last_reg;

endmodule

`default_nettype wire

[design/gcs_checker.sv]
// Port-level assertion checker of the grid coordinate shuffler and its bind.
`default_nettype none

module gcs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_ready,
    input  logic                           rsp_valid,
    input  logic                           rsp_ready,
    input  logic [gcs_pkg::CELL_W-1:0]     rsp_cell_row,
    input  logic [gcs_pkg::CELL_W-1:0]     rsp_cell_col,
    input  logic                           rsp_shuffle_done,
    input  logic                           rsp_last,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gcs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gcs_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [gcs_pkg::APB_DATA_W-1:0] prdata
);
    import gcs_pkg::*;

    // A stalled response transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
        && $stable({rsp_cell_row, rsp_cell_col, rsp_shuffle_done, rsp_last}))
    else $error("response changed while stalled");

    // Every accepted request makes the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("request taken without a busy cycle");

    // A new response only appears after the block has been working on a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
    else $error("response appeared while idle");

    // A written grid side reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[APB_ADDR_W-1:2] == REG_GRID_SIDE)
        ##1 (psel && !pwrite && paddr[APB_ADDR_W-1:2] == REG_GRID_SIDE)
        |-> prdata[SIDE_W-1:0] == $past(pwdata[SIDE_W-1:0]))
    else $error("grid side readback mismatch");

endmodule

bind grid_coordinate_shuffler gcs_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_cell_row     (rsp.cell_row),
    .rsp_cell_col     (rsp.cell_col),
    .rsp_shuffle_done (rsp.shuffle_done),
    .rsp_last         (rsp.last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata)
);

`default_nettype wire

[sim/grid_coordinate_shuffler_check.sv]
// Checker of the grid coordinate shuffler: predicts every response and compares it field by field.
`default_nettype none

module grid_coordinate_shuffler_check (
    input  logic                           clk,
    input  logic                           rst_n,
    gcs_req_if                             req,
    gcs_rsp_if                             rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gcs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gcs_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [gcs_pkg::APB_DATA_W-1:0] prdata,
    input  logic                           pready,
    output int                             failures,
    output int                             outstanding
);
    import gcs_pkg::*;

    localparam logic [APB_ADDR_W-1:0] GRID_SIDE_ADDR = {REG_GRID_SIDE, 2'b00};

    typedef struct packed {
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
        logic              done;
        logic              last;
    } cell_result_t;

    logic [SIDE_W-1:0] side_reg;
    cell_t             perm_table [TABLE_DEPTH];
    int unsigned       cell_count;
    int unsigned       shuffle_pos;
    int unsigned       read_pos;
    cell_result_t      expected_cells [$];

    function automatic cell_result_t predict_cell(input logic [OPCODE_W-1:0] op,
                                                  input logic [RAND_W-1:0]   rnd);
        cell_result_t res;
        int unsigned  side_eff;
        int unsigned  swap_pos;
        int unsigned  k;
        cell_t        held;
        res = '0;
        if (op == OP_START)
        begin
            side_eff = (side_reg == '0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
            cell_count = side_eff * side_eff;
            for (k = 0; k < cell_count; k++)
            begin
                perm_table[k].row = COORD_W'(k / side_eff);
                perm_table[k].col = COORD_W'(k % side_eff);
            end
            shuffle_pos = cell_count - 1;
            read_pos = 0;
        end
        else if (op == OP_SHUFFLE)
        begin
            if (cell_count != 0 && shuffle_pos > 0 && shuffle_pos < cell_count)
            begin
                swap_pos = 32'(rnd) % (shuffle_pos + 1);
                held = perm_table[shuffle_pos];
                perm_table[shuffle_pos] = perm_table[swap_pos];
                perm_table[swap_pos] = held;
                shuffle_pos = shuffle_pos - 1;
            end
        end
        else if (op == OP_READ)
        begin
            if (cell_count != 0 && read_pos < cell_count)
            begin
                res.row = perm_table[read_pos].row;
                res.col = perm_table[read_pos].col;
                if (read_pos + 1 >= cell_count)
                begin
                    res.last = 1'b1;
                    read_pos = 0;
                end
                else
                begin
                    read_pos = read_pos + 1;
                end
            end
        end
        res.done = (cell_count != 0 && shuffle_pos == 0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t seen;
        cell_result_t want;
        if (!rst_n)
        begin
            side_reg = GRID_SIDE_RESET;
            cell_count = 0;
            shuffle_pos = 0;
            read_pos = 0;
            failures = 0;
            expected_cells.delete();
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == GRID_SIDE_ADDR)
            begin
                if (pwrite)
                begin
                    side_reg = pwdata[SIDE_W-1:0];
                end
                else if (prdata != APB_DATA_W'(side_reg))
                begin
                    $error("grid_side: expected %0d, actual %0d", side_reg, prdata);
                    failures = failures + 1;
                end
            end
            if (req.valid && req.ready)
            begin
                expected_cells.push_back(predict_cell(req.opcode, req.random_word));
            end
            if (rsp.valid && rsp.ready)
            begin
                seen = '{rsp.cell_row, rsp.cell_col, rsp.shuffle_done, rsp.last};
                if (expected_cells.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    failures = failures + 1;
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (seen.row !== want.row)
                    begin
                        $error("cell_row: expected %0d, actual %0d", want.row, seen.row);
                        failures = failures + 1;
                    end
                    if (seen.col !== want.col)
                    begin
                        $error("cell_col: expected %0d, actual %0d", want.col, seen.col);
                        failures = failures + 1;
                    end
                    if (seen.done !== want.done)
                    begin
                        $error("shuffle_done: expected %0d, actual %0d", want.done, seen.done);
                        failures = failures + 1;
                    end
                    if (seen.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, seen.last);
                        failures = failures + 1;
                    end
                end
            end
            outstanding <= expected_cells.size();
        end
    end

endmodule

`default_nettype wire

[sim/grid_coordinate_shuffler_tb.sv]
// Top of the grid coordinate shuffler testbench: clock, reset, stimulus, idling and verdict.
`default_nettype none

module grid_coordinate_shuffler_tb;
    import gcs_pkg::*;

    localparam logic [OPCODE_W-1:0]   OP_UNUSED      = 2'd3;
    localparam logic [APB_ADDR_W-1:0] GRID_SIDE_ADDR = {REG_GRID_SIDE, 2'b00};
    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    failures;
    int                    outstanding;
    int                    cycle = 0;
    int                    items_sent = 0;
    int                    hold_left = 0;
    int                    hold_idx = 0;
    logic                  calm;

    gcs_req_if req();
    gcs_rsp_if rsp();

    grid_coordinate_shuffler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    grid_coordinate_shuffler_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #2 clk = ~clk;

    assign calm = (cycle >= 3000 && cycle < 9000);

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT)
        begin
            $display("grid_coordinate_shuffler_tb: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            rsp.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_idx < 2 && items_sent >= (hold_idx + 1) * 500)
        begin
            rsp.ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_idx <= hold_idx + 1;
        end
        else
        begin
            rsp.ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [RAND_W-1:0] rnd);
        while (!calm && $urandom_range(99) < 21)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.opcode <= op;
        req.random_word <= rnd;
        do @(posedge clk); while (!req.ready);
        items_sent++;
    endtask

    task automatic drain_responses();
        req.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_grid_side(input logic [SIDE_W-1:0] side);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= GRID_SIDE_ADDR;
        pwdata <= APB_DATA_W'(side);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_sequence(input int unsigned cells);
        int unsigned steps;
        int unsigned reads;
        int unsigned s;
        send_item(OP_START, 31'($urandom));
        steps = ($urandom_range(3) == 0) ? $urandom_range(cells + 2) : cells - 1;
        for (s = 0; s < steps && items_sent < ITEM_TARGET; s++)
        begin
            if ($urandom_range(15) == 0)
                send_item(OP_READ, 31'($urandom));
            if ($urandom_range(39) == 0)
                send_item(2'($urandom_range(3)), 31'($urandom));
            send_item(OP_SHUFFLE, 31'($urandom));
        end
        reads = ($urandom_range(3) == 0) ? $urandom_range(2 * cells + 1)
                                         : cells + $urandom_range(2);
        for (s = 0; s < reads && items_sent < ITEM_TARGET; s++)
        begin
            if ($urandom_range(39) == 0)
                send_item(2'($urandom_range(3)), 31'($urandom));
            send_item(OP_READ, 31'($urandom));
        end
    endtask

    initial
    begin
        int                phase;
        logic [SIDE_W-1:0] side_pick;
        int unsigned       side_eff;
        logic [SIDE_W-1:0] preset_sides [5];
        preset_sides = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd2};
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.opcode <= OP_START;
        req.random_word <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before any start, reads and shuffles answer with an empty table.
        send_item(OP_READ, '1);
        send_item(OP_SHUFFLE, '1);
        send_item(OP_UNUSED, '0);
        send_item(OP_START, '0);
        send_item(OP_READ, '0);
        send_item(OP_SHUFFLE, '1);
        send_item(OP_SHUFFLE, '0);
        send_item(OP_UNUSED, '1);
        drain_responses();
        set_grid_side(5'd2);
        send_item(OP_START, '1);
        send_item(OP_SHUFFLE, '1);
        send_item(OP_READ, '1);
        send_item(OP_SHUFFLE, '0);
        send_item(OP_SHUFFLE, 31'($urandom));
        send_item(OP_SHUFFLE, 31'($urandom));
        repeat (5) send_item(OP_READ, 31'($urandom));
        drain_responses();
        set_grid_side(5'd0);
        send_item(OP_START, '0);
        send_item(OP_READ, '0);
        send_item(OP_READ, '1);
        send_item(OP_SHUFFLE, '1);
        drain_responses();
        set_grid_side(5'd31);
        send_item(OP_START, '1);
        send_item(OP_READ, '0);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase < 5)
                side_pick = preset_sides[phase];
            else if ($urandom_range(4) == 0)
                side_pick = 5'($urandom_range(31));
            else
                side_pick = 5'($urandom_range(1, 8));
            phase++;
            drain_responses();
            set_grid_side(side_pick);
            side_eff = (side_pick == '0) ? 1 : ((side_pick > MAX_SIDE) ? MAX_SIDE : side_pick);
            repeat ($urandom_range(1, 3)) run_sequence(side_eff * side_eff);
        end

        drain_responses();
        repeat (40) @(posedge clk);
        if (failures == 0)
            $display("grid_coordinate_shuffler_tb: clean");
        else
            $display("grid_coordinate_shuffler_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
